/* rtl/core/vrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package vrt_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_GRID_DIM = 16;
    localparam int COORD_W      = 25;
    localparam int S_W          = COORD_W + 1;
    localparam int MAG_W        = COORD_W;
    localparam int SUM_W        = 2 * MAG_W + 2;
    localparam int ROOT_W       = SUM_W / 2;
    localparam int DIST_W       = FRAC_BITS + 1;
    localparam int DIVD_W       = DIST_W + ROOT_W + 1;
    localparam int REM_W        = ROOT_W + 4;
    localparam int CRD_W        = COORD_W - FRAC_BITS + 1;
    localparam int DIM_W        = 5;
    localparam int PITCH_W      = 24;
    localparam int LEN_W        = 24;
    localparam int IDX_W        = 12;
    localparam int OFS_W        = 32;
    localparam int PROD_W       = OFS_W + PITCH_W;
    localparam int MAX_RESULTS  = 3 * MAX_GRID_DIM - 2;
    localparam int NRES_W       = 6;
    localparam int WALK_CAP     = 3 * ((1 << (COORD_W - FRAC_BITS + 1)) + 4);
    localparam int GUARD_W      = 12;
    localparam int CNT_W        = 6;

    typedef enum logic [2:0] {
        CFG_GRID_X  = 3'd0,
        CFG_GRID_Y  = 3'd1,
        CFG_GRID_Z  = 3'd2,
        CFG_PITCH_X = 3'd3,
        CFG_PITCH_Y = 3'd4,
        CFG_PITCH_Z = 3'd5
    } vrt_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_AXMUL,
        ST_DIVB,
        ST_DIVS,
        ST_DECIDE,
        ST_WALK,
        ST_MUL,
        ST_PUSH,
        ST_FIN
    } vrt_state_t;

    typedef struct packed {
        logic [2:0][DIM_W-1:0]   dim;
        logic [2:0][PITCH_W-1:0] pitch;
    } vrt_cfg_t;

    typedef struct packed {
        logic               start;
        logic               sqrt_mode;
        logic [SUM_W-1:0]   operand;
        logic [MAG_W-1:0]   divisor;
    } vrt_unit_req_t;

    typedef struct packed {
        logic              busy;
        logic [DIVD_W-1:0] result;
    } vrt_unit_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/vrt_divsqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module vrt_divsqrt
    import vrt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vrt_unit_req_t req,
    output vrt_unit_rsp_t      rsp
);

    logic [SUM_W-1:0]  opd_reg, opd_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] res_reg, res_next;
    logic [MAG_W-1:0]  div_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              mode_reg;
    logic [REM_W-1:0]  rem_sh, trial;
    logic              ge;

    always_comb
    begin
        if (mode_reg)
        begin
            rem_sh = {rem_reg[REM_W-3:0], opd_reg[SUM_W-1 -: 2]};
            trial  = {res_reg[REM_W-3:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[REM_W-2:0], opd_reg[SUM_W-1]};
            trial  = REM_W'(div_reg);
        end
        ge = (rem_sh >= trial);

        opd_next  = opd_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            opd_next  = req.sqrt_mode ? req.operand
                                      : {req.operand[DIVD_W-1:0], {(SUM_W-DIVD_W){1'b0}}};
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = req.sqrt_mode ? CNT_W'(ROOT_W) : CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            opd_next  = mode_reg ? {opd_reg[SUM_W-3:0], 2'b00} : {opd_reg[SUM_W-2:0], 1'b0};
            rem_next  = ge ? rem_sh - trial : rem_sh;
            res_next  = {res_reg[DIVD_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opd_reg <= opd_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        if (req.start)
        begin
            mode_reg <= req.sqrt_mode;
            div_reg  <= req.divisor;
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.result = res_reg;

endmodule
`default_nettype wire

/* rtl/core/vrt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module vrt_ctrl
    import vrt_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire vrt_cfg_t                   cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       in_line,
    input  wire logic [2:0][COORD_W-1:0]    in_start,
    input  wire logic [2:0][COORD_W-1:0]    in_end,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [IDX_W-1:0]                out_index,
    output logic [LEN_W-1:0]                out_length,
    output logic                            out_last,
    output logic                            out_empty
);

    vrt_state_t state_reg, state_next;
    vrt_unit_req_t ureq;
    vrt_unit_rsp_t ursp;

    logic                         line_reg, line_next;
    logic                         same_reg, same_next;
    logic [2:0][CRD_W-1:0]        crd_reg, crd_next;
    logic [2:0][FRAC_BITS-1:0]    frac_reg, frac_next;
    logic [2:0][MAG_W-1:0]        mag_reg, mag_next;
    logic [2:0]                   sgn_reg, sgn_next;
    logic [2:0][OFS_W-1:0]        off_reg, off_next;
    logic [2:0][OFS_W-1:0]        step_reg, step_next;
    logic [OFS_W-1:0]             rem_reg, rem_next;
    logic [ROOT_W-1:0]            l_reg, l_next;
    logic [SUM_W-1:0]             sum_reg, sum_next, sq_reg, sq_next;
    logic [1:0]                   ax_reg, ax_next;
    logic [2:0]                   cnt_reg, cnt_next;
    logic [NRES_W-1:0]            n_reg, n_next;
    logic [GUARD_W-1:0]           guard_reg, guard_next;
    logic                         entered_reg, entered_next;
    logic [OFS_W-1:0]             d_reg, d_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic                         pend_reg, pend_next;
    logic [IDX_W-1:0]             pidx_reg, pidx_next;
    logic [LEN_W-1:0]             plen_reg, plen_next;
    logic                         ov_reg, ov_next;
    logic [IDX_W-1:0]             oidx_reg, oidx_next;
    logic [LEN_W-1:0]             olen_reg, olen_next;
    logic                         olast_reg, olast_next;
    logic                         oempty_reg, oempty_next;

    vrt_divsqrt u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .rsp   (ursp)
    );

    logic [2:0][S_W-1:0]   s_w;
    logic [2:0][CRD_W-1:0] endc_w;
    logic                  ins;
    logic [1:0]            id;
    logic [OFS_W-1:0]      d_w, rem_after;
    logic [IDX_W-1:0]      inner, idx_w;
    logic [DIST_W-1:0]     bnd_dist;
    logic [OFS_W-1:0]      quo_sat;
    logic [LEN_W-1:0]      newlen, lsat;
    logic                  can_push;
    logic                  go_on;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s_w[a] = in_line ? S_W'($signed(in_end[a]))
                             : S_W'($signed(in_end[a])) - S_W'($signed(in_start[a]));
            endc_w[a] = CRD_W'($signed(in_end[a][COORD_W-1:FRAC_BITS]));
        end

        ins = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (crd_reg[a][CRD_W-1] || (crd_reg[a][CRD_W-2:0] >= (CRD_W-1)'(cfg.dim[a])))
            begin
                ins = 1'b0;
            end
        end

        id = 2'd0;
        if (off_reg[1] < off_reg[0])
        begin
            id = 2'd1;
        end
        if (off_reg[2] < off_reg[id])
        begin
            id = 2'd2;
        end
        d_w = off_reg[id];
        if (!line_reg && (d_w > rem_reg))
        begin
            d_w = rem_reg;
        end
        rem_after = rem_reg - d_w;

        inner = IDX_W'(crd_reg[1][3:0]) + IDX_W'(cfg.dim[1]) * IDX_W'(crd_reg[2][3:0]);
        idx_w = IDX_W'(crd_reg[0][3:0]) + IDX_W'(cfg.dim[0]) * inner;

        bnd_dist = sgn_reg[ax_reg] ? DIST_W'(frac_reg[ax_reg])
                                   : DIST_W'(1 << FRAC_BITS) - DIST_W'(frac_reg[ax_reg]);
        quo_sat = (|ursp.result[DIVD_W-1:OFS_W]) ? '1 : ursp.result[OFS_W-1:0];
        newlen  = (|prod_reg[PROD_W-1:LEN_W+FRAC_BITS]) ? '1
                                                        : prod_reg[LEN_W+FRAC_BITS-1:FRAC_BITS];
        lsat    = (|l_reg[ROOT_W-1:LEN_W]) ? '1 : l_reg[LEN_W-1:0];
        can_push = !ov_reg || out_ready;
        go_on = line_reg ? (ins && (n_reg < NRES_W'(MAX_RESULTS)))
                         : ((rem_reg != '0) && (guard_reg < GUARD_W'(WALK_CAP))
                            && (n_reg < NRES_W'(MAX_RESULTS)));
    end

    always_comb
    begin
        state_next   = state_reg;
        line_next    = line_reg;
        same_next    = same_reg;
        crd_next     = crd_reg;
        frac_next    = frac_reg;
        mag_next     = mag_reg;
        sgn_next     = sgn_reg;
        off_next     = off_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        l_next       = l_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        ax_next      = ax_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        guard_next   = guard_reg;
        entered_next = entered_reg;
        d_next       = d_reg;
        idx_next     = idx_reg;
        prod_next    = prod_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        plen_next    = plen_reg;
        ov_next      = ov_reg && !out_ready;
        oidx_next    = oidx_reg;
        olen_next    = olen_reg;
        olast_next   = olast_reg;
        oempty_next  = oempty_reg;
        ureq.start     = 1'b0;
        ureq.sqrt_mode = 1'b0;
        ureq.operand   = '0;
        ureq.divisor   = mag_reg[ax_reg];
        in_ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    line_next = in_line;
                    same_next = 1'b1;
                    for (int a = 0; a < 3; a++)
                    begin
                        crd_next[a]  = CRD_W'($signed(in_start[a][COORD_W-1:FRAC_BITS]));
                        frac_next[a] = in_start[a][FRAC_BITS-1:0];
                        sgn_next[a]  = s_w[a][S_W-1];
                        mag_next[a]  = s_w[a][S_W-1] ? MAG_W'(-s_w[a]) : MAG_W'(s_w[a]);
                        if (crd_next[a] != endc_w[a])
                        begin
                            same_next = 1'b0;
                        end
                    end
                    sum_next   = '0;
                    sq_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                sum_next = sum_reg + sq_reg;
                if (cnt_reg == 3'd3)
                begin
                    ureq.start     = 1'b1;
                    ureq.sqrt_mode = 1'b1;
                    ureq.operand   = sum_reg + sq_reg;
                    state_next     = ST_ROOT;
                end
                else
                begin
                    sq_next  = SUM_W'(mag_reg[cnt_reg[1:0]]) * SUM_W'(mag_reg[cnt_reg[1:0]]);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (!ursp.busy)
                begin
                    l_next     = ursp.result[ROOT_W-1:0];
                    ax_next    = 2'd0;
                    state_next = ST_AXMUL;
                end
            end
            ST_AXMUL:
            begin
                if (mag_reg[ax_reg] == '0)
                begin
                    off_next[ax_reg]  = '1;
                    step_next[ax_reg] = '1;
                    ax_next    = ax_reg + 1'b1;
                    state_next = (ax_reg == 2'd2) ? ST_DECIDE : ST_AXMUL;
                end
                else
                begin
                    ureq.start   = 1'b1;
                    ureq.operand = SUM_W'(bnd_dist) * SUM_W'(l_reg);
                    state_next   = ST_DIVB;
                end
            end
            ST_DIVB:
            begin
                if (!ursp.busy)
                begin
                    off_next[ax_reg] = quo_sat;
                    ureq.start   = 1'b1;
                    ureq.operand = SUM_W'({l_reg, {FRAC_BITS{1'b0}}});
                    state_next   = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                if (!ursp.busy)
                begin
                    step_next[ax_reg] = quo_sat;
                    ax_next    = ax_reg + 1'b1;
                    state_next = (ax_reg == 2'd2) ? ST_DECIDE : ST_AXMUL;
                end
            end
            ST_DECIDE:
            begin
                rem_next     = OFS_W'(l_reg);
                n_next       = '0;
                guard_next   = '0;
                entered_next = 1'b0;
                pend_next    = 1'b0;
                if (!line_reg)
                begin
                    if (same_reg)
                    begin
                        if (ins)
                        begin
                            pend_next = 1'b1;
                            pidx_next = idx_w;
                            plen_next = lsat;
                        end
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
                else
                begin
                    state_next = (mag_reg != '0) ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK:
            begin
                if (!go_on || (!line_reg && !ins && entered_reg))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    if (ins)
                    begin
                        d_next       = d_w;
                        ax_next      = id;
                        idx_next     = idx_w;
                        n_next       = n_reg + 1'b1;
                        entered_next = 1'b1;
                        state_next   = ST_MUL;
                    end
                    crd_next[id] = sgn_reg[id] ? crd_reg[id] - 1'b1 : crd_reg[id] + 1'b1;
                    for (int a = 0; a < 3; a++)
                    begin
                        off_next[a] = off_reg[a] - d_w;
                    end
                    if (line_reg)
                    begin
                        off_next[id] = step_reg[id];
                    end
                    else
                    begin
                        rem_next     = rem_after;
                        guard_next   = guard_reg + 1'b1;
                        off_next[id] = (step_reg[id] < rem_after) ? step_reg[id] : rem_after;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(d_reg) * PROD_W'(cfg.pitch[ax_reg]);
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!pend_reg || can_push)
                begin
                    if (pend_reg)
                    begin
                        ov_next     = 1'b1;
                        oidx_next   = pidx_reg;
                        olen_next   = plen_reg;
                        olast_next  = 1'b0;
                        oempty_next = 1'b0;
                    end
                    pend_next  = 1'b1;
                    pidx_next  = idx_reg;
                    plen_next  = newlen;
                    state_next = ST_WALK;
                end
            end
            ST_FIN:
            begin
                if (can_push)
                begin
                    ov_next     = 1'b1;
                    oidx_next   = pend_reg ? pidx_reg : '0;
                    olen_next   = pend_reg ? plen_reg : '0;
                    olast_next  = 1'b1;
                    oempty_next = !pend_reg;
                    pend_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg    <= line_next;
        same_reg    <= same_next;
        crd_reg     <= crd_next;
        frac_reg    <= frac_next;
        mag_reg     <= mag_next;
        sgn_reg     <= sgn_next;
        off_reg     <= off_next;
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        l_reg       <= l_next;
        sum_reg     <= sum_next;
        sq_reg      <= sq_next;
        ax_reg      <= ax_next;
        cnt_reg     <= cnt_next;
        n_reg       <= n_next;
        guard_reg   <= guard_next;
        entered_reg <= entered_next;
        d_reg       <= d_next;
        idx_reg     <= idx_next;
        prod_reg    <= prod_next;
        pidx_reg    <= pidx_next;
        plen_reg    <= plen_next;
        oidx_reg    <= oidx_next;
        olen_reg    <= olen_next;
        olast_reg   <= olast_next;
        oempty_reg  <= oempty_next;
    end

    assign out_valid  = ov_reg;
    assign out_index  = oidx_reg;
    assign out_length = olen_reg;
    assign out_last   = olast_reg;
    assign out_empty  = oempty_reg;

endmodule
`default_nettype wire

/* rtl/core/voxel_ray_traversal.sv */
`timescale 1ns / 1ps
`default_nettype none
// Walks one ray through the voxel grid and returns one request per voxel crossed inside
// the grid, with the last one marked; a ray that misses the grid returns a single request
// flagged empty. A ray is taken only when the block is idle. Setup takes the ray, sums
// the squares, takes the square root, and when all three direction components are
// nonzero runs six divisions, then decides, all on one shared shift-subtract unit; a
// zero direction component skips its two divisions. Each voxel step inside the grid
// then selects the axis, scales by the pitch and hands off the result, and a step
// outside it only selects the axis; the hand-off waits while the output is stalled.
module voxel_ray_traversal
    import vrt_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, zero fill
    input  wire logic [151:0]   s_tdata,
    // operation
    input  wire logic [0:0]     s_tuser,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // voxel_index, path_length, zero fill
    output logic [39:0]         m_tdata,
    // empty_res
    output logic [0:0]          m_tuser,
    output logic                m_tlast,
    input  wire logic           wr_en,
    input  wire logic [2:0]     wr_index,
    input  wire logic [23:0]    wr_data
);

    logic [2:0][DIM_W-1:0]   gsize_reg;
    logic [2:0][PITCH_W-1:0] pitch_reg;
    vrt_cfg_t                cfg;
    logic [2:0][COORD_W-1:0] start_w, end_w;
    logic [IDX_W-1:0]        out_index;
    logic [LEN_W-1:0]        out_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg <= {3{DIM_W'(MAX_GRID_DIM)}};
            pitch_reg <= {3{PITCH_W'(1 << FRAC_BITS)}};
        end
        else if (wr_en)
        begin
            unique case (vrt_cfg_idx_t'(wr_index))
                CFG_GRID_X:  gsize_reg[0] <= wr_data[DIM_W-1:0];
                CFG_GRID_Y:  gsize_reg[1] <= wr_data[DIM_W-1:0];
                CFG_GRID_Z:  gsize_reg[2] <= wr_data[DIM_W-1:0];
                CFG_PITCH_X: pitch_reg[0] <= wr_data[PITCH_W-1:0];
                CFG_PITCH_Y: pitch_reg[1] <= wr_data[PITCH_W-1:0];
                CFG_PITCH_Z: pitch_reg[2] <= wr_data[PITCH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            cfg.dim[a]   = (gsize_reg[a] > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM)
                                                                 : gsize_reg[a];
            cfg.pitch[a] = pitch_reg[a];
            start_w[a]   = s_tdata[a*COORD_W +: COORD_W];
            end_w[a]     = s_tdata[(a+3)*COORD_W +: COORD_W];
        end
    end

    vrt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_line    (s_tuser[0]),
        .in_start   (start_w),
        .in_end     (end_w),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_length (out_length),
        .out_last   (m_tlast),
        .out_empty  (m_tuser[0])
    );

    assign m_tdata = {4'b0000, out_length, out_index};

endmodule
`default_nettype wire
